/* design/bftr_pkg.sv */
// bftr_pkg: shared types, constants and the 8x8 font table for the text renderer
// no dependencies
package bftr_pkg;

	localparam int unsigned COORD_WIDTH = 13;
	localparam int unsigned ADDR_WIDTH  = 24;
	localparam int unsigned COLOR_WIDTH = 32;
	localparam int unsigned GLYPH_COUNT = 128;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;
	localparam logic [COORD_WIDTH-1:0] LINE_ADVANCE = COORD_WIDTH'(10);
	localparam logic [COORD_WIDTH-1:0] GLYPH_ADVANCE = COORD_WIDTH'(8);
	localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};

	localparam logic [0:0] REG_HORIZ_RES = 1'b0;
	localparam logic [0:0] REG_VERT_RES  = 1'b1;

	localparam logic [COORD_WIDTH-1:0] HORIZ_RES_RESET = COORD_WIDTH'(1280);
	localparam logic [COORD_WIDTH-1:0] VERT_RES_RESET  = COORD_WIDTH'(1080);

	typedef logic [COORD_WIDTH-1:0] coord_t;

	// saturating add of two coordinates
	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic [COORD_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COORD_WIDTH] ? COORD_MAX : s[COORD_WIDTH-1:0];
	endfunction

	// one glyph row of the font; bit 0 is the leftmost column
	function automatic logic [7:0] font_row(input logic [6:0] code, input logic [2:0] row);
		logic [63:0] g;
		case (code)
			7'd33:  g = 64'h0018_0018_183C_3C18;
			7'd34:  g = 64'h0000_0000_0000_3636;
			7'd35:  g = 64'h0036_367F_367F_3636;
			7'd36:  g = 64'h000C_1F30_1E03_3E0C;
			7'd37:  g = 64'h0063_660C_1833_6300;
			7'd38:  g = 64'h006E_333B_6E1C_361C;
			7'd39:  g = 64'h0000_0000_0003_0606;
			7'd40:  g = 64'h0018_0C06_0606_0C18;
			7'd41:  g = 64'h0006_0C18_1818_0C06;
			7'd42:  g = 64'h0000_663C_FF3C_6600;
			7'd43:  g = 64'h0000_0C0C_3F0C_0C00;
			7'd44:  g = 64'h060C_0C00_0000_0000;
			7'd45:  g = 64'h0000_0000_3F00_0000;
			7'd46:  g = 64'h000C_0C00_0000_0000;
			7'd47:  g = 64'h0001_0306_0C18_3060;
			7'd48:  g = 64'h003E_676F_7B73_633E;
			7'd49:  g = 64'h003F_0C0C_0C0C_0E0C;
			7'd50:  g = 64'h003F_3306_1C30_331E;
			7'd51:  g = 64'h001E_3330_1C30_331E;
			7'd52:  g = 64'h0078_307F_3336_3C38;
			7'd53:  g = 64'h001E_3330_301F_033F;
			7'd54:  g = 64'h001E_3333_1F03_061C;
			7'd55:  g = 64'h000C_0C0C_1830_333F;
			7'd56:  g = 64'h001E_3333_1E33_331E;
			7'd57:  g = 64'h000E_1830_3E33_331E;
			7'd58:  g = 64'h000C_0C00_000C_0C00;
			7'd59:  g = 64'h060C_0C00_000C_0C00;
			7'd60:  g = 64'h0018_0C06_0306_0C18;
			7'd61:  g = 64'h0000_3F00_003F_0000;
			7'd62:  g = 64'h0006_0C18_3018_0C06;
			7'd63:  g = 64'h000C_000C_1830_331E;
			7'd64:  g = 64'h001E_037B_7B7B_633E;
			7'd65:  g = 64'h0033_333F_3333_1E0C;
			7'd66:  g = 64'h003F_6666_3E66_663F;
			7'd67:  g = 64'h003C_6603_0303_663C;
			7'd68:  g = 64'h001F_3666_6666_361F;
			7'd69:  g = 64'h007F_4616_1E16_467F;
			7'd70:  g = 64'h000F_0616_1E16_467F;
			7'd71:  g = 64'h007C_6673_0303_663C;
			7'd72:  g = 64'h0033_3333_3F33_3333;
			7'd73:  g = 64'h001E_0C0C_0C0C_0C1E;
			7'd74:  g = 64'h001E_3333_3030_3078;
			7'd75:  g = 64'h0067_6636_1E36_6667;
			7'd76:  g = 64'h007F_6646_0606_060F;
			7'd77:  g = 64'h0063_636B_7F7F_7763;
			7'd78:  g = 64'h0063_6373_7B6F_6763;
			7'd79:  g = 64'h001C_3663_6363_361C;
			7'd80:  g = 64'h000F_0606_3E66_663F;
			7'd81:  g = 64'h0038_1E3B_3333_331E;
			7'd82:  g = 64'h0067_6636_3E66_663F;
			7'd83:  g = 64'h001E_3338_0E07_331E;
			7'd84:  g = 64'h001E_0C0C_0C0C_2D3F;
			7'd85:  g = 64'h003F_3333_3333_3333;
			7'd86:  g = 64'h000C_1E33_3333_3333;
			7'd87:  g = 64'h0063_777F_6B63_6363;
			7'd88:  g = 64'h0063_361C_1C36_6363;
			7'd89:  g = 64'h001E_0C0C_1E33_3333;
			7'd90:  g = 64'h007F_664C_1831_637F;
			7'd91:  g = 64'h001E_0606_0606_061E;
			7'd92:  g = 64'h0040_6030_180C_0603;
			7'd93:  g = 64'h001E_1818_1818_181E;
			7'd94:  g = 64'h0000_0000_6336_1C08;
			7'd95:  g = 64'hFF00_0000_0000_0000;
			7'd96:  g = 64'h0000_0000_0018_0C0C;
			7'd97:  g = 64'h006E_333E_301E_0000;
			7'd98:  g = 64'h003B_6666_3E06_0607;
			7'd99:  g = 64'h001E_3303_331E_0000;
			7'd100: g = 64'h006E_3333_3E30_3038;
			7'd101: g = 64'h001E_033F_331E_0000;
			7'd102: g = 64'h000F_0606_0F06_361C;
			7'd103: g = 64'h1F30_3E33_336E_0000;
			7'd104: g = 64'h0067_6666_6E36_0607;
			7'd105: g = 64'h001E_0C0C_0C0E_000C;
			7'd106: g = 64'h1E33_3330_3030_0030;
			7'd107: g = 64'h0067_361E_3666_0607;
			7'd108: g = 64'h001E_0C0C_0C0C_0C0E;
			7'd109: g = 64'h0063_6B7F_7F33_0000;
			7'd110: g = 64'h0033_3333_331F_0000;
			7'd111: g = 64'h001E_3333_331E_0000;
			7'd112: g = 64'h0F06_3E66_663B_0000;
			7'd113: g = 64'h7830_3E33_336E_0000;
			7'd114: g = 64'h000F_0666_6E3B_0000;
			7'd115: g = 64'h001F_301E_033E_0000;
			7'd116: g = 64'h0018_2C0C_0C3E_0C08;
			7'd117: g = 64'h006E_3333_3333_0000;
			7'd118: g = 64'h000C_1E33_3333_0000;
			7'd119: g = 64'h0036_7F7F_6B63_0000;
			7'd120: g = 64'h0063_361C_3663_0000;
			7'd121: g = 64'h1F30_3E33_3333_0000;
			7'd122: g = 64'h003F_260C_193F_0000;
			7'd123: g = 64'h0038_0C0C_070C_0C38;
			7'd124: g = 64'h0018_1818_0018_1818;
			7'd125: g = 64'h0007_0C0C_380C_0C07;
			7'd126: g = 64'h0000_0000_0000_3B6E;
			default: g = 64'h0;
		endcase
		return g[{row, 3'b000} +: 8];
	endfunction

endpackage

/* design/bftr_addr_unit.sv */
// bftr_addr_unit: shared multiply-add that forms col + row * width, one result registered
// depends on bftr_pkg
module bftr_addr_unit (
	input  logic                         clk,
	input  logic                         en,
	input  bftr_pkg::coord_t             col,
	input  bftr_pkg::coord_t             row,
	input  bftr_pkg::coord_t             width,
	output logic [bftr_pkg::ADDR_WIDTH-1:0] addr_q
);
	logic [2*bftr_pkg::COORD_WIDTH-1:0] prod;

	// one 13x13 multiply and add per cycle while en is high
	always_comb begin
		prod = row * width;
	end

	// result holds while the sequencer waits
	always_ff @(posedge clk) begin
		if (en) begin
			addr_q <= bftr_pkg::ADDR_WIDTH'(prod + {{bftr_pkg::COORD_WIDTH{1'b0}}, col});
		end
	end
endmodule

/* design/bitmap_font_text_renderer.sv */
// Character generator for an 8x8 bitmap font. Each character transaction is taken while stall
// is low; newline and carriage return only move the pen, and the block is ready again on the
// next cycle. Any other code is scanned over all 64 glyph positions, row by row and left to
// right, one position per cycle unless a found pixel waits on a full output register, through
// a single shared multiply-add address unit; stall stays high until the scan is done and the
// last found pixel is flushed, and longer while a found pixel waits on the output register.
// One found pixel is held back until the next one shows up, so last_pixel can flag
// the final write of a character; codes without a glyph write nothing but take the same time.
// Depends on bftr_pkg and bftr_addr_unit.
module bitmap_font_text_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  char_code,
	input  logic        new_string,
	input  logic [11:0] origin_x,
	input  logic [11:0] origin_y,
	input  logic [31:0] ink_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] pixel_address,
	output logic [31:0] pixel_color,
	output logic        last_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

	state_t state_q;
	bftr_pkg::coord_t horiz_q, vert_q, pen_col_q, pen_row_q, line_start_q;
	bftr_pkg::coord_t base_col_q, base_row_q;
	logic [6:0]  code_q;
	logic [31:0] color_q;
	logic [5:0]  pos_q;
	logic        hit_s1;
	logic        held_q;
	logic [bftr_pkg::ADDR_WIDTH-1:0] held_addr_q;
	logic [bftr_pkg::ADDR_WIDTH-1:0] addr_s1;

	bftr_pkg::coord_t col_c, row_c;
	logic [13:0] col_w, row_w;
	logic [7:0]  glyph_bits;
	logic        bit_c, hit_c, last_pos;
	logic        out_free;
	logic        advance_c, push_c, push_last_c;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	assign stall     = (state_q != ST_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q <= bftr_pkg::HORIZ_RES_RESET;
			vert_q  <= bftr_pkg::VERT_RES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bftr_pkg::REG_HORIZ_RES: horiz_q <= cfg_data;
				bftr_pkg::REG_VERT_RES:  vert_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// current glyph position, unbounded so clipping is exact
	always_comb begin
		col_w      = {1'b0, base_col_q} + 14'(pos_q[2:0]);
		row_w      = {1'b0, base_row_q} + 14'(pos_q[5:3]);
		col_c      = col_w[12:0];
		row_c      = row_w[12:0];
		glyph_bits = bftr_pkg::font_row(code_q, pos_q[5:3]);
		bit_c      = glyph_bits[pos_q[2:0]];
		hit_c      = bit_c && !col_w[13] && !row_w[13] && (col_c < horiz_q) && (row_c < vert_q);
		last_pos   = (pos_q == 6'd63);
	end

	// scan moves on unless a new hit would push out the held one into a busy output
	always_comb begin
		advance_c   = (state_q == ST_SCAN) && !(hit_s1 && held_q && !out_free);
		push_c      = out_free && held_q &&
			(((state_q == ST_SCAN) && hit_s1) || (state_q == ST_DRAIN));
		push_last_c = !hit_s1;
	end

	bftr_addr_unit u_addr (
		.clk   (clk),
		.en    (advance_c),
		.col   (col_c),
		.row   (row_c),
		.width (horiz_q),
		.addr_q(addr_s1)
	);

	// sequencer: scan positions, hold one found pixel until the next is found or scan ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pen_col_q     <= '0;
			pen_row_q     <= '0;
			line_start_q  <= '0;
			base_col_q    <= '0;
			base_row_q    <= '0;
			code_q        <= '0;
			color_q       <= '0;
			pos_q         <= '0;
			hit_s1        <= 1'b0;
			held_q        <= 1'b0;
			held_addr_q   <= '0;
			out_valid     <= 1'b0;
			pixel_address <= '0;
			pixel_color   <= '0;
			last_pixel    <= 1'b0;
		end else begin
			// output register
			if (push_c) begin
				pixel_address <= held_addr_q;
				pixel_color   <= color_q;
				last_pixel    <= push_last_c;
				out_valid     <= 1'b1;
			end else if (out_free) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						bftr_pkg::coord_t pc, pr, ls;
						pc = new_string ? {1'b0, origin_x} : pen_col_q;
						pr = new_string ? {1'b0, origin_y} : pen_row_q;
						ls = new_string ? {1'b0, origin_x} : line_start_q;
						line_start_q <= ls;
						if (char_code == bftr_pkg::CHAR_NEWLINE) begin
							pen_col_q <= pc;
							pen_row_q <= bftr_pkg::sat_add(pr, bftr_pkg::LINE_ADVANCE);
						end else if (char_code == bftr_pkg::CHAR_RETURN) begin
							pen_col_q <= ls;
							pen_row_q <= pr;
						end else begin
							pen_col_q  <= bftr_pkg::sat_add(pc, bftr_pkg::GLYPH_ADVANCE);
							pen_row_q  <= pr;
							base_col_q <= pc;
							base_row_q <= pr;
							code_q     <= char_code[7] ? 7'd0 : char_code[6:0];
							color_q    <= ink_color;
							pos_q      <= '0;
							hit_s1     <= 1'b0;
							held_q     <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (advance_c) begin
						if (hit_s1) begin
							held_addr_q <= addr_s1;
							held_q      <= 1'b1;
						end
						hit_s1 <= hit_c;
						pos_q  <= pos_q + 6'd1;
						if (last_pos) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// take the hit of the final position, then send the held pixel as last
					if (hit_s1) begin
						if (!held_q || out_free) begin
							held_addr_q <= addr_s1;
							held_q      <= 1'b1;
							hit_s1      <= 1'b0;
						end
					end else if (!held_q || out_free) begin
						held_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_no_take_while_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> stall;
	endproperty
	a_no_take_while_busy: assert property (p_no_take_while_busy) else $error("busy take");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && out_stall) |=>
				(out_valid && $stable(pixel_address) && $stable(last_pixel));
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("output changed under stall");

	property p_idle_empty;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_IDLE) |-> (!held_q && !hit_s1);
	endproperty
	a_idle_empty: assert property (p_idle_empty) else $error("pixel left behind at idle");
endmodule
